// ===== sv/hpp_pkg.sv =====
// Package for the haptic pattern player: shared types, register indexes,
// reset values and the segment timing functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpp_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Command queue between the front and the back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int MS_W   = 16;

  localparam logic [MS_W-1:0] TAP_MS_RST         = 16'd100;
  localparam logic [MS_W-1:0] LONG_MS_RST        = 16'd500;
  localparam logic [MS_W-1:0] ALERT_TAP_MS_RST   = 16'd150;
  localparam logic [MS_W-1:0] ALERT_FINAL_MS_RST = 16'd400;

  typedef enum logic [2:0] {
    REG_MOTOR_ENABLED  = 3'd0,
    REG_TAP_MS         = 3'd1,
    REG_LONG_MS        = 3'd2,
    REG_ALERT_TAP_MS   = 3'd3,
    REG_ALERT_FINAL_MS = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    PAT_SHORT  = 2'd0,
    PAT_DOUBLE = 2'd1,
    PAT_LONG   = 2'd2,
    PAT_ALERT  = 2'd3
  } pat_e;

  localparam logic [2:0] ALERT_FINAL_SEG = 3'd4;

  typedef struct packed {
    logic            motor_enabled;
    logic [MS_W-1:0] tap_ms;
    logic [MS_W-1:0] long_ms;
    logic [MS_W-1:0] alert_tap_ms;
    logic [MS_W-1:0] alert_final_ms;
  } cfg_t;

  typedef struct packed {
    logic       is_play;
    logic [2:0] code;
  } cmd_t;

  function automatic logic [2:0] seg_total(pat_e pat);
    logic [2:0] n;
    case (pat)
      PAT_DOUBLE: n = 3'd3;
      PAT_ALERT:  n = 3'd5;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [MS_W-1:0] seg_length(cfg_t c, pat_e pat, logic [2:0] idx);
    logic [MS_W-1:0] len;
    case (pat)
      PAT_SHORT, PAT_DOUBLE: len = c.tap_ms;
      PAT_LONG:              len = c.long_ms;
      default:               len = (idx == ALERT_FINAL_SEG) ? c.alert_final_ms
                                                            : c.alert_tap_ms;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hpp_front.sv =====
// Front stage of the haptic pattern player: registers each incoming item and
// classifies it into a play or tick command. Depends on hpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpp_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [2:0]  in_pattern_code,
  output logic             cmd_valid,
  output hpp_pkg::cmd_t    cmd,
  input  wire logic        cmd_ready
);
  import hpp_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r;

  assign in_ready  = !vld_r || cmd_ready;
  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Ticks carry no code; clear it so the back sees a clean command.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.is_play <= in_req_type;
      cmd_r.code    <= in_req_type ? in_pattern_code : 3'd0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpp_cmdq.sv =====
// Short command queue that decouples the front stage from the player.
// Depends on hpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpp_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire hpp_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output hpp_pkg::cmd_t      pop_cmd
);
  import hpp_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_ready = (cnt_r != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? CMDQ_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? CMDQ_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CMDQ_CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CMDQ_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpp_back.sv =====
// Back stage of the haptic pattern player: request queue, segment sequencer
// and the registered result. Depends on hpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpp_back #(
  parameter int QUEUE_DEPTH = hpp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hpp_pkg::cfg_t cfg,
  input  wire logic          stop,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire hpp_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_motor_drive,
  output logic               out_accepted,
  output logic               out_busy_res
);
  import hpp_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [2:0]      q_r [QUEUE_DEPTH];
  logic [2:0]      q_nxt [QUEUE_DEPTH];
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            playing_r, playing_nxt;
  pat_e            pat_r, pat_nxt;
  logic [2:0]      seg_r, seg_nxt;
  logic [MS_W-1:0] ms_r, ms_nxt;
  logic            motor_r, motor_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            motor_drive_r, accepted_r, busy_r;
  logic            acc;
  logic            take;
  logic [2:0]      head;
  logic [2:0]      seg_inc;

  assign take      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = take;
  assign head      = q_r[0];
  assign seg_inc   = 3'(seg_r + 3'd1);

  always_comb begin
    q_nxt       = q_r;
    cnt_nxt     = cnt_r;
    playing_nxt = playing_r;
    pat_nxt     = pat_r;
    seg_nxt     = seg_r;
    ms_nxt      = ms_r;
    motor_nxt   = motor_r;
    acc         = 1'b0;
    if (take) begin
      if (cmd.is_play) begin
        if (cfg.motor_enabled && (cnt_r < CW'(QUEUE_DEPTH))) begin
          q_nxt[cnt_r[IW-1:0]] = cmd.code;
          cnt_nxt              = CW'(cnt_r + 1'b1);
          acc                  = 1'b1;
        end
      end else if (!playing_r) begin
        // An idle player starts at most one queued request per tick.
        if (cnt_r != '0) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_nxt[i] = q_r[i+1];
          end
          cnt_nxt = CW'(cnt_r - 1'b1);
          if (!head[2]) begin
            pat_nxt     = pat_e'(head[1:0]);
            seg_nxt     = 3'd0;
            playing_nxt = 1'b1;
            ms_nxt      = seg_length(cfg, pat_e'(head[1:0]), 3'd0);
            motor_nxt   = 1'b1;
          end
        end
      end else if (ms_r > MS_W'(1)) begin
        ms_nxt = MS_W'(ms_r - 1'b1);
      end else if (seg_inc >= seg_total(pat_r)) begin
        playing_nxt = 1'b0;
        seg_nxt     = 3'd0;
        ms_nxt      = '0;
        motor_nxt   = 1'b0;
      end else begin
        seg_nxt   = seg_inc;
        ms_nxt    = seg_length(cfg, pat_r, seg_inc);
        motor_nxt = !seg_inc[0];
      end
    end
    out_valid_nxt = take || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || stop) begin
      cnt_r     <= '0;
      playing_r <= 1'b0;
      pat_r     <= PAT_SHORT;
      seg_r     <= 3'd0;
      ms_r      <= '0;
      motor_r   <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      playing_r <= playing_nxt;
      pat_r     <= pat_nxt;
      seg_r     <= seg_nxt;
      ms_r      <= ms_nxt;
      motor_r   <= motor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (take) begin
      motor_drive_r <= cfg.motor_enabled && motor_nxt;
      accepted_r    <= acc;
      busy_r        <= cfg.motor_enabled && ((cnt_nxt != '0) || playing_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_drive = motor_drive_r;
  assign out_accepted    = accepted_r;
  assign out_busy_res    = busy_r;

endmodule

`default_nettype wire

// ===== sv/haptic_pattern_player.sv =====
// Haptic pattern player. A stream of items, each either a play request or a
// one-millisecond tick, drives a vibration motor through short, double, long
// and alert patterns; every item returns one result with the motor level, the
// request's acceptance and busy. The block takes one item per clock cycle
// while the output is not stalled; an item passes through the input
// register, the command queue and the result register. Timing registers
// must be written through the APB port only while idle; the block itself
// does not enforce this. Writing zero to motor_enabled flushes the queue and
// stops playback. Depends on hpp_pkg, hpp_front, hpp_cmdq and hpp_back.
`timescale 1ns / 1ps
`default_nettype none

module haptic_pattern_player #(
  parameter int QUEUE_DEPTH = hpp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_req_type,
  input  wire logic [2:0]                 in_pattern_code,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_motor_drive,
  output logic                            out_accepted,
  output logic                            out_busy_res,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [hpp_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [hpp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [hpp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import hpp_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  logic     stop;
  reg_idx_e idx;
  logic     f_valid, f_ready, b_valid, b_ready;
  cmd_t     f_cmd, b_cmd;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_e'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign stop       = wr_en && (idx == REG_MOTOR_ENABLED) && !cfg_pwdata[0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MOTOR_ENABLED:  cfg_nxt.motor_enabled  = cfg_pwdata[0];
        REG_TAP_MS:         cfg_nxt.tap_ms         = cfg_pwdata[MS_W-1:0];
        REG_LONG_MS:        cfg_nxt.long_ms        = cfg_pwdata[MS_W-1:0];
        REG_ALERT_TAP_MS:   cfg_nxt.alert_tap_ms   = cfg_pwdata[MS_W-1:0];
        REG_ALERT_FINAL_MS: cfg_nxt.alert_final_ms = cfg_pwdata[MS_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOTOR_ENABLED:  cfg_prdata = CFG_DW'(cfg_r.motor_enabled);
      REG_TAP_MS:         cfg_prdata = CFG_DW'(cfg_r.tap_ms);
      REG_LONG_MS:        cfg_prdata = CFG_DW'(cfg_r.long_ms);
      REG_ALERT_TAP_MS:   cfg_prdata = CFG_DW'(cfg_r.alert_tap_ms);
      REG_ALERT_FINAL_MS: cfg_prdata = CFG_DW'(cfg_r.alert_final_ms);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_enabled  <= 1'b1;
      cfg_r.tap_ms         <= TAP_MS_RST;
      cfg_r.long_ms        <= LONG_MS_RST;
      cfg_r.alert_tap_ms   <= ALERT_TAP_MS_RST;
      cfg_r.alert_final_ms <= ALERT_FINAL_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hpp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_pattern_code (in_pattern_code),
    .cmd_valid       (f_valid),
    .cmd             (f_cmd),
    .cmd_ready       (f_ready)
  );

  hpp_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  hpp_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .stop            (stop),
    .cmd_valid       (b_valid),
    .cmd_ready       (b_ready),
    .cmd             (b_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_motor_drive (out_motor_drive),
    .out_accepted    (out_accepted),
    .out_busy_res    (out_busy_res)
  );

endmodule

`default_nettype wire

// ===== sv/hpp_checker.sv =====
// Port-level checks for the haptic pattern player, bound to the top level.
// Uses only the top level's result and configuration handshake ports.
`timescale 1ns / 1ps
`default_nettype none

module hpp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_motor_drive,
  input wire logic out_accepted,
  input wire logic out_busy_res,
  input wire logic cfg_pready
);

  // An accepted request sits in the queue, so the block must report busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_busy_res)
    else $error("accepted request without busy");

  // The motor is only driven while a pattern plays.
  a_motor_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_drive |-> out_busy_res)
    else $error("motor driven while not busy");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_drive)
      && $stable(out_accepted) && $stable(out_busy_res))
    else $error("stalled result changed");

endmodule

bind haptic_pattern_player hpp_checker u_hpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_motor_drive (out_motor_drive),
  .out_accepted    (out_accepted),
  .out_busy_res    (out_busy_res),
  .cfg_pready      (cfg_pready)
);

`default_nettype wire
